>>> rtl/core/kss_pkg.sv
// Package for the shared-store stack block: sizes, codes and the request record.
// No dependencies; every other file of the block but kss_ram imports it.
`default_nettype none

package kss_pkg;

    // Store and stack sizes
    localparam int DEPTH      = 64;
    localparam int NUM_STACKS = 8;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the ports
    localparam int SID_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // Derived widths; a link holds an entry index or the null code DEPTH
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINK_W = $clog2(DEPTH + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(DEPTH - 1);
    localparam logic [VAL_W-1:0]  VAL_NEG1  = {VAL_W{1'b1}};

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_EXEC = 1'b1
    } t_bstate;

    // Classified request as it travels from front to back
    typedef struct packed {
        t_op                   op;
        logic                  sid_ok;
        logic [STK_W-1:0]      sid;
        logic [DATA_WIDTH-1:0] data;
    } t_req;

endpackage

`default_nettype wire

>>> rtl/core/k_stacks_shared_store.sv
// Top level: several LIFO stacks sharing one linked entry store with a free list.
// Depends on kss_pkg, kss_front, kss_queue and kss_back.
//
//  Channel  Direction  Handshake           Payload
//  request  in         i_valid / o_stall   i_req_type, i_stack_id, i_push_value
//  result   out        o_valid / i_stall   o_pop_value, o_status
//
// A successful push or pop goes through the back end's idle and exec states: the link word of the
// chosen entry is read from the link RAM, then the tops and free head are relinked.
// A refused push or empty pop is answered from the idle state. Requests queue two deep ahead of the back end.
// Reset is synchronous and clears all stacks; no clearing pass is needed.
// A stalled result waits in the output register while the queue keeps filling.
`default_nettype none

module k_stacks_shared_store
    import kss_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_req_type,
    input  wire logic [SID_W-1:0]        i_stack_id,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [VAL_W-1:0]      o_pop_value,
    output logic [STATUS_W-1:0]          o_status
);

    logic q_wr;
    logic q_full;
    logic q_valid;
    logic q_rd;
    t_req q_in;
    t_req q_out;

    kss_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_stack_id   (i_stack_id),
        .i_push_value (i_push_value),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_q_item     (q_in)
    );

    kss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_rd    (q_rd)
    );

    kss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .o_q_rd      (q_rd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pop_value (o_pop_value),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

>>> rtl/core/kss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/kss_front.sv
// Front end: takes request words and classifies them into request records.
// Depends on kss_pkg.
`default_nettype none

module kss_front
    import kss_pkg::*;
(
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_req_type,
    input  wire logic [SID_W-1:0]        i_stack_id,
    input  wire logic signed [VAL_W-1:0] i_push_value,
    input  wire logic                    i_q_full,
    output logic                         o_q_wr,
    output t_req                         o_q_item
);

    // Hold off the sender while the queue is full
    assign o_stall = i_q_full;
    assign o_q_wr  = i_valid && !i_q_full;

    // Decode operation, check the stack number, keep the value in store width
    always_comb begin
        o_q_item.op     = t_op'(i_req_type);
        o_q_item.sid_ok = (32'(i_stack_id) < NUM_STACKS);
        o_q_item.sid    = STK_W'(i_stack_id);
        o_q_item.data   = DATA_WIDTH'($unsigned(i_push_value));
    end

endmodule

`default_nettype wire

>>> rtl/core/kss_queue.sv
// Two-entry queue of request records between front and back.
// Depends on kss_pkg.
`default_nettype none

module kss_queue
    import kss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_req      i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_req      o_item,
    input  wire logic i_rd
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // Store the incoming record
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kss_back.sv
// Back end: runs pushes and pops against the stack tops, free head and store.
// Depends on kss_pkg and kss_ram.
`default_nettype none

module kss_back
    import kss_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  t_req                     i_q_item,
    output logic                     o_q_rd,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [VAL_W-1:0]  o_pop_value,
    output logic [STATUS_W-1:0]      o_status
);

    t_bstate r_state, n_state;
    t_op     r_op;
    logic [STK_W-1:0]  r_sid;
    logic [ADDR_W-1:0] r_idx;
    logic [LINK_W-1:0] r_top [NUM_STACKS];
    logic [LINK_W-1:0] r_free_head;
    logic [DEPTH-1:0]  r_link_vld;

    // Output register
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_out_value;
    t_status              r_out_status;

    logic                 out_load;
    logic [VAL_W-1:0]     out_value;
    t_status              out_status;

    // Control of state updates
    logic                 start;
    logic                 free_we;
    logic [LINK_W-1:0]    free_wdata;
    logic                 top_we;
    logic [STK_W-1:0]     top_wsel;
    logic [LINK_W-1:0]    top_wdata;

    // Store ports
    logic                    data_we;
    logic [ADDR_W-1:0]       raddr;
    logic [DATA_WIDTH-1:0]   data_rd;
    logic                    link_we;
    logic [LINK_W-1:0]       link_wdata;
    logic [LINK_W-1:0]       link_ram_rd;
    logic [LINK_W-1:0]       link_rd;
    logic [LINK_W-1:0]       top_cur;
    logic                    out_free;

    assign top_cur  = r_top[i_q_item.sid];
    assign out_free = !r_out_valid || !i_stall;

    // Read the top entry on pop, the free-head entry on push
    assign raddr = (i_q_item.op == OP_POP) ? ADDR_W'(top_cur) : ADDR_W'(r_free_head);

    kss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (ADDR_W'(r_free_head)),
        .i_wdata (i_q_item.data),
        .i_raddr (raddr),
        .o_rdata (data_rd)
    );

    kss_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_idx),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_ram_rd)
    );

    // Unwritten links read as their reset chain: next entry, last one null
    always_comb begin
        if (r_link_vld[r_idx]) begin
            link_rd = link_ram_rd;
        end else if (r_idx == LAST_IDX) begin
            link_rd = LINK_NULL;
        end else begin
            link_rd = LINK_W'(r_idx) + LINK_W'(1);
        end
    end

    // Sequencer: classify against state in idle, then relink in the exec state
    always_comb begin
        n_state    = r_state;
        o_q_rd     = 1'b0;
        start      = 1'b0;
        out_load   = 1'b0;
        out_value  = '0;
        out_status = ST_OK;
        data_we    = 1'b0;
        link_we    = 1'b0;
        link_wdata = r_free_head;
        free_we    = 1'b0;
        free_wdata = link_rd;
        top_we     = 1'b0;
        top_wsel   = r_sid;
        top_wdata  = link_rd;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_rd = 1'b1;
                    unique case (i_q_item.op)
                        OP_PUSH: begin
                            if (!i_q_item.sid_ok || r_free_head == LINK_NULL) begin
                                out_load   = 1'b1;
                                out_status = ST_FULL;
                            end else begin
                                data_we = 1'b1;
                                start   = 1'b1;
                                n_state = BS_EXEC;
                            end
                        end
                        OP_POP: begin
                            if (!i_q_item.sid_ok || top_cur == LINK_NULL) begin
                                out_load   = 1'b1;
                                out_value  = VAL_NEG1;
                                out_status = ST_EMPTY;
                            end else begin
                                start   = 1'b1;
                                n_state = BS_EXEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_EXEC: begin
                n_state  = BS_IDLE;
                out_load = 1'b1;
                link_we  = 1'b1;
                free_we  = 1'b1;
                top_we   = 1'b1;
                unique case (r_op)
                    OP_PUSH: begin
                        link_wdata = r_top[r_sid];
                        free_wdata = link_rd;
                        top_wdata  = LINK_W'(r_idx);
                    end
                    OP_POP: begin
                        link_wdata = r_free_head;
                        free_wdata = LINK_W'(r_idx);
                        top_wdata  = link_rd;
                        out_value  = VAL_W'(data_rd);
                    end
                    default: ;
                endcase
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Hold the operation being relinked
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op  <= i_q_item.op;
            r_sid <= i_q_item.sid;
            r_idx <= ADDR_W'(raddr);
        end
        if (out_load) begin
            r_out_value  <= out_value;
            r_out_status <= out_status;
        end
    end

    // State, tops, free head, link valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_free_head <= '0;
            r_link_vld  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= LINK_NULL;
            end
        end else begin
            r_state <= n_state;
            if (free_we) begin
                r_free_head <= free_wdata;
            end
            if (top_we) begin
                r_top[top_wsel] <= top_wdata;
            end
            if (link_we) begin
                r_link_vld[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

>>> rtl/core/kss_checker.sv
// Port-level checks for the shared-store stack block, bound to its top level.
// Depends on kss_pkg and k_stacks_shared_store.
`default_nettype none

module kss_checker
    import kss_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic signed [VAL_W-1:0] o_pop_value,
    input wire logic [STATUS_W-1:0]     o_status
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pop_value) && $stable(o_status))
        else $error("result dropped or changed while stalled");

    // Drop any result after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Empty pops answer all ones
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_pop_value == VAL_NEG1)
        else $error("empty pop without -1");

    // Refused pushes answer zero, and no unknown status code appears
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_pop_value == '0)
        else $error("refused push with non-zero value");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_FULL || o_status == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind k_stacks_shared_store kss_checker u_kss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_pop_value (o_pop_value),
    .o_status    (o_status)
);

`default_nettype wire
